### rtl/swrm_pkg.sv
// ----------------------------------------------------------------------------
// swrm_pkg
// Shared types and constants of the sparse window rms meter.
// ----------------------------------------------------------------------------
package swrm_pkg;

	localparam int LEN_W      = 13;
	localparam int LEN_RESET  = 1024;
	localparam int SAMPLE_W   = 16;
	localparam int SQ_W       = 31;
	localparam int TAPS       = 16;
	localparam int TAP_SHIFT  = $clog2(TAPS);
	localparam int TAP_CNT_W  = $clog2(TAPS + 1);
	localparam int OFF_W      = LEN_W + TAP_SHIFT;
	localparam int SUM_W      = SQ_W + TAP_SHIFT;
	localparam int RAD_W      = 32;
	localparam int ROOT_W     = 16;
	localparam int REM_W      = ROOT_W + 3;
	localparam int STEP_CNT_W = $clog2(ROOT_W + 1);
	localparam int ADDR_W     = 3;
	localparam int REG_SEL_B  = 2;

	// register indexes
	localparam logic REG_WINDOW_LENGTH = 1'b0;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_SQUARE,
		ST_WRITE,
		ST_READ,
		ST_ROOT,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic             start;
		logic [RAD_W-1:0] radicand;
	} root_cmd_t;

	typedef struct packed {
		logic              done;
		logic [ROOT_W-1:0] root;
	} root_rsp_t;

endpackage

### rtl/swrm_ram.sv
// ----------------------------------------------------------------------------
// swrm_ram
// Single write port, single read port memory with registered read data.
// ----------------------------------------------------------------------------
module swrm_ram #(
	parameter int DEPTH  = 4096,
	parameter int AW     = 12,
	parameter int DW     = 31
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [DW-1:0] wdata,
	input  logic [AW-1:0] raddr,
	output logic [DW-1:0] rdata
);

	logic [DW-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

### rtl/swrm_root.sv
// ----------------------------------------------------------------------------
// swrm_root
// Iterative integer square root, one result bit per cycle (floor).
// ----------------------------------------------------------------------------
module swrm_root (
	input  logic                clk,
	input  logic                arst_n,
	input  swrm_pkg::root_cmd_t cmd,
	output swrm_pkg::root_rsp_t rsp
);

	logic [swrm_pkg::RAD_W-1:0]      rad_q;
	logic [swrm_pkg::REM_W-1:0]      rem_q;
	logic [swrm_pkg::ROOT_W-1:0]     root_q;
	logic [swrm_pkg::STEP_CNT_W-1:0] cnt_q;
	logic                            done_q;

	logic [swrm_pkg::REM_W-1:0] rem_sh;
	logic [swrm_pkg::REM_W-1:0] trial;
	logic                       fits;

	// shared compare and subtract
	always_comb begin
		rem_sh = {rem_q[swrm_pkg::REM_W-3:0], rad_q[swrm_pkg::RAD_W-1 -: 2]};
		trial  = swrm_pkg::REM_W'({root_q, 2'b01});
		fits   = rem_sh >= trial;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else if (cmd.start) begin
			cnt_q  <= swrm_pkg::STEP_CNT_W'(swrm_pkg::ROOT_W);
			done_q <= 1'b0;
		end else begin
			done_q <= cnt_q == swrm_pkg::STEP_CNT_W'(1);
			if (cnt_q != '0) begin
				cnt_q <= cnt_q - swrm_pkg::STEP_CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			rad_q  <= cmd.radicand;
			rem_q  <= '0;
			root_q <= '0;
		end else if (cnt_q != '0) begin
			rad_q  <= {rad_q[swrm_pkg::RAD_W-3:0], 2'b00};
			rem_q  <= fits ? rem_sh - trial : rem_sh;
			root_q <= {root_q[swrm_pkg::ROOT_W-2:0], fits};
		end
	end

	assign rsp.done = done_q;
	assign rsp.root = root_q;

endmodule

### rtl/sparse_window_rms_meter.sv
// ----------------------------------------------------------------------------
// sparse_window_rms_meter
// Sliding window rms level from a sparse set of taps of a ring of squares.
// ----------------------------------------------------------------------------
// After reset the block first sweeps the square store to zero, one entry a
// cycle, and takes no sample during that pass (register writes are taken).
// After the word is taken, a sample's level goes through these steps: the
// square, the write to the ring, the tap reads through the store's single
// read port, the bit-serial square root (16 steps, then its finish is seen)
// and the hand-over. The input is not ready again until the level is handed
// over. The level sits in an output register, so the next sample is taken
// while it waits; a level still waiting when the next one is ready holds the
// block until it is taken.
module sparse_window_rms_meter #(
	parameter int MAX_WINDOW = 4096
) (
	input  logic                        clk,
	input  logic                        arst_n,
	// sample word: sample[15:0]
	input  logic                        s_tvalid,
	output logic                        s_tready,
	input  logic [15:0]                 s_tdata,
	// result word: rms_level[15:0]
	output logic                        m_tvalid,
	input  logic                        m_tready,
	output logic [15:0]                 m_tdata,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [swrm_pkg::ADDR_W-1:0] paddr,
	input  logic [31:0]                 pwdata,
	output logic [31:0]                 prdata,
	output logic                        pready
);

	localparam int AW = $clog2(MAX_WINDOW);

	swrm_pkg::state_t state_q, state_d;

	logic [swrm_pkg::LEN_W-1:0]     len_q;
	logic [swrm_pkg::LEN_W-1:0]     eff_len;
	logic [AW-1:0]                  wp_q;
	logic [AW:0]                    wp_inc;
	logic [AW-1:0]                  clr_q;
	logic [swrm_pkg::SAMPLE_W-1:0]  sample_q;
	logic [swrm_pkg::SQ_W-1:0]      sq_q;
	logic [swrm_pkg::TAP_CNT_W-1:0] tap_q;
	logic [swrm_pkg::OFF_W-1:0]     off_q;
	logic [swrm_pkg::SUM_W-1:0]     sum_q;
	logic [swrm_pkg::SUM_W-1:0]     sum_d;
	logic [swrm_pkg::ROOT_W-1:0]    out_q;
	logic                           out_valid_q;

	logic                           cfg_wr;
	logic                           accept;
	logic                           clr_last;
	logic                           taps_done;
	logic                           load_out;
	logic                           ram_we;
	logic [AW-1:0]                  ram_waddr;
	logic [swrm_pkg::SQ_W-1:0]      ram_wdata;
	logic [AW-1:0]                  ram_raddr;
	logic [swrm_pkg::SQ_W-1:0]      ram_rdata;
	logic signed [31:0]             product;

	swrm_pkg::root_cmd_t root_cmd;
	swrm_pkg::root_rsp_t root_rsp;

	// register port
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite &&
		(paddr[swrm_pkg::REG_SEL_B] == swrm_pkg::REG_WINDOW_LENGTH);
	assign prdata = (paddr[swrm_pkg::REG_SEL_B] == swrm_pkg::REG_WINDOW_LENGTH) ?
		32'(len_q) : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q <= swrm_pkg::LEN_W'(swrm_pkg::LEN_RESET);
		end else if (cfg_wr) begin
			len_q <= pwdata[swrm_pkg::LEN_W-1:0];
		end
	end

	// zero means one, clamp to the store depth
	always_comb begin
		if (len_q == '0) begin
			eff_len = swrm_pkg::LEN_W'(1);
		end else if (32'(len_q) > 32'(MAX_WINDOW)) begin
			eff_len = swrm_pkg::LEN_W'(MAX_WINDOW);
		end else begin
			eff_len = len_q;
		end
	end

	assign wp_inc    = {1'b0, wp_q} + (AW+1)'(1);
	assign clr_last  = clr_q == AW'(MAX_WINDOW - 1);
	assign taps_done = tap_q == swrm_pkg::TAP_CNT_W'(swrm_pkg::TAPS);
	assign product   = $signed(sample_q) * $signed(sample_q);
	assign sum_d     = sum_q + swrm_pkg::SUM_W'(ram_rdata);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			swrm_pkg::ST_CLEAR: begin
				if (clr_last) begin
					state_d = swrm_pkg::ST_IDLE;
				end
			end
			swrm_pkg::ST_IDLE: begin
				if (s_tvalid) begin
					state_d = swrm_pkg::ST_SQUARE;
				end
			end
			swrm_pkg::ST_SQUARE: state_d = swrm_pkg::ST_WRITE;
			swrm_pkg::ST_WRITE:  state_d = swrm_pkg::ST_READ;
			swrm_pkg::ST_READ: begin
				if (taps_done) begin
					state_d = swrm_pkg::ST_ROOT;
				end
			end
			swrm_pkg::ST_ROOT: begin
				if (root_rsp.done) begin
					state_d = swrm_pkg::ST_DONE;
				end
			end
			swrm_pkg::ST_DONE: begin
				if (!out_valid_q || m_tready) begin
					state_d = swrm_pkg::ST_IDLE;
				end
			end
			default: state_d = swrm_pkg::ST_CLEAR;
		endcase
	end

	// outputs of the sequencer
	always_comb begin
		s_tready          = 1'b0;
		ram_we            = 1'b0;
		ram_waddr         = wp_q;
		ram_wdata         = sq_q;
		root_cmd.start    = 1'b0;
		root_cmd.radicand = swrm_pkg::RAD_W'(sum_d >> swrm_pkg::TAP_SHIFT);
		load_out          = 1'b0;
		case (state_q)
			swrm_pkg::ST_CLEAR: begin
				ram_we    = 1'b1;
				ram_waddr = clr_q;
				ram_wdata = '0;
			end
			swrm_pkg::ST_IDLE:  s_tready = 1'b1;
			swrm_pkg::ST_WRITE: ram_we = 1'b1;
			swrm_pkg::ST_READ:  root_cmd.start = taps_done;
			swrm_pkg::ST_DONE:  load_out = !out_valid_q || m_tready;
			default: begin
			end
		endcase
	end

	assign accept    = s_tvalid && s_tready;
	assign ram_raddr = AW'(off_q >> swrm_pkg::TAP_SHIFT);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= swrm_pkg::ST_CLEAR;
			clr_q       <= '0;
			wp_q        <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == swrm_pkg::ST_CLEAR) begin
				clr_q <= clr_q + AW'(1);
			end
			// stale position wraps before the write, then advance
			if (accept && (32'(wp_q) >= 32'(eff_len))) begin
				wp_q <= '0;
			end else if (state_q == swrm_pkg::ST_WRITE) begin
				wp_q <= (32'(wp_inc) >= 32'(eff_len)) ? '0 : wp_inc[AW-1:0];
			end
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			sample_q <= s_tdata[swrm_pkg::SAMPLE_W-1:0];
		end
		if (state_q == swrm_pkg::ST_SQUARE) begin
			sq_q <= product[swrm_pkg::SQ_W-1:0];
		end
		if (state_q == swrm_pkg::ST_WRITE) begin
			tap_q <= '0;
			off_q <= '0;
			sum_q <= '0;
		end else if (state_q == swrm_pkg::ST_READ) begin
			if (!taps_done) begin
				tap_q <= tap_q + swrm_pkg::TAP_CNT_W'(1);
				off_q <= off_q + swrm_pkg::OFF_W'(eff_len);
			end
			if (tap_q != '0) begin
				sum_q <= sum_d;
			end
		end
		if (load_out) begin
			out_q <= root_rsp.root;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_q;

	swrm_ram #(
		.DEPTH (MAX_WINDOW),
		.AW    (AW),
		.DW    (swrm_pkg::SQ_W)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	swrm_root u_root (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (root_cmd),
		.rsp    (root_rsp)
	);

endmodule
